@@ rtl/core/sppo_pkg.sv @@
// sppo_pkg: shared sizes, types and sequencer states for the polygon orderer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sppo_pkg;
	localparam int MaxPoints = 64;
	localparam int CoordBits = 16;
	localparam int IdxBits = $clog2(MaxPoints);
	localparam int CntBits = $clog2(MaxPoints + 1);
	localparam int DiffBits = CoordBits + 1;
	localparam int ProdBits = 2 * DiffBits;
	localparam int AccBits = ProdBits + 1;

	typedef logic [IdxBits-1:0] idx_t;
	typedef logic [CntBits-1:0] cnt_t;
	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [DiffBits-1:0] diff_t;
	typedef logic signed [AccBits-1:0] acc_t;

	typedef enum logic [4:0] {
		ST_LOAD, ST_REF_RD, ST_REF_CMP,
		ST_INS_START, ST_INS_RD_ORD, ST_INS_RD_PT, ST_INS_M1, ST_INS_M2,
		ST_INS_D1, ST_INS_D2, ST_INS_DEC, ST_INS_PLACE,
		ST_CHK_START, ST_CHK_RD_ORD, ST_CHK_RD_PT, ST_CHK_M1, ST_CHK_M2, ST_CHK_DEC,
		ST_OUT_RD, ST_OUT_WAIT, ST_OUT_SHOW, ST_FAIL
	} state_t;

	// operation select for the shared multiply-accumulate unit
	typedef enum logic [1:0] {MAC_LOAD_MUL, MAC_SUB_MUL, MAC_ADD_MUL} mac_op_t;

	typedef struct packed {
		logic    en;
		mac_op_t op;
	} mac_ctl_t;
endpackage
`default_nettype wire

@@ rtl/core/simple_polygon_polar_order.sv @@
// simple_polygon_polar_order: top level, point stores, sequencer and output register
// depends on sppo_pkg and sppo_mac
`timescale 1ns / 1ps
`default_nettype none
// Points load one beat per cycle into on-chip stores. The beat with final_point
// set starts the ordering and in_stall stays high until the last result beat has
// been taken. The ordering runs on one shared multiply-accumulate unit: a reference
// scan, then an insertion sort where each compare forms the cross product and, when
// it is zero, also compares the two distances (two products for the cross product,
// two more for each distance), then a collinear-tail scan and the result beats.
// Results are zero-based input positions; no_polygon marks the single result
// given for fewer than three points or an all-collinear set.
module simple_polygon_polar_order (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  sppo_pkg::coord_t    coord_x,
	input  sppo_pkg::coord_t    coord_y,
	input  wire                 final_point,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [5:0]          point_index,
	output logic                no_polygon,
	output logic                end_of_run
);
	import sppo_pkg::*;

	coord_t x_mem [MaxPoints];
	coord_t y_mem [MaxPoints];
	idx_t   ord_mem [MaxPoints];

	state_t state_q, state_d;
	cnt_t   cnt_q;      // point_count
	cnt_t   n_q;        // set size
	idx_t   ref_q;
	coord_t rx_q, ry_q, cx_q, cy_q; // reference and best/current coordinates
	cnt_t   i_q, j_q, m_q;
	idx_t   oj_q;       // order_store[j-1] in the insertion sort
	coord_t ax_q, ay_q, bx_q, by_q;
	acc_t   t_q;        // saved distance term
	idx_t   got_q;
	logic   tail_q;     // emitting the reversed tail

	// registered memory reads
	idx_t   pt_addr, ord_addr;
	coord_t px_rd, py_rd;
	idx_t   ord_rd;
	logic   in_acc, out_acc;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		px_rd <= x_mem[pt_addr];
		py_rd <= y_mem[pt_addr];
		ord_rd <= ord_mem[ord_addr];
		if (in_acc && cnt_q < cnt_t'(MaxPoints)) begin
			x_mem[cnt_q[IdxBits-1:0]] <= coord_x;
			y_mem[cnt_q[IdxBits-1:0]] <= coord_y;
		end
	end

	// ordering store write
	logic ord_we;
	idx_t ord_wa, ord_wd;
	always_ff @(posedge clk) begin
		if (ord_we) ord_mem[ord_wa] <= ord_wd;
	end

	// shared multiply-accumulate
	mac_ctl_t mac_ctl;
	diff_t    mac_a, mac_b;
	acc_t     acc;
	sppo_mac u_mac (.clk(clk), .ctl(mac_ctl), .op_a(mac_a), .op_b(mac_b), .acc(acc));

	function automatic diff_t dif(coord_t a, coord_t b);
		return diff_t'(a) - diff_t'(b);
	endfunction

	// insertion compare is sequenced in D1/D2 with a distance sub-phase
	logic dphase_q; // 0: cross done in acc, 1: distances
	logic [1:0] dstep_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:      if (in_acc && final_point) state_d = ST_REF_RD;
			ST_REF_RD:    state_d = ST_REF_CMP;
			ST_REF_CMP:   state_d = (i_q + 1'b1 >= n_q) ? ST_INS_START : ST_REF_RD;
			ST_INS_START: begin
				if (i_q >= n_q) state_d = ST_CHK_START;
				else if (i_q[IdxBits-1:0] == ref_q) state_d = ST_INS_START;
				else state_d = ST_INS_RD_ORD;
			end
			ST_INS_RD_ORD: state_d = (j_q > cnt_t'(1)) ? ST_INS_RD_PT : ST_INS_PLACE;
			ST_INS_RD_PT:  state_d = ST_INS_M1;
			ST_INS_M1:     state_d = ST_INS_M2;
			ST_INS_M2:     state_d = ST_INS_D1;
			ST_INS_D1: begin
				if (!dphase_q)
					state_d = (acc != 0) ? (acc > 0 ? ST_INS_DEC : ST_INS_PLACE)
					                     : ST_INS_D1;
				else
					state_d = (dstep_q == 2'd3) ? ST_INS_D2 : ST_INS_D1;
			end
			// acc holds dist2(j), t_q holds dist2(i)
			ST_INS_D2:     state_d = (t_q < acc || (t_q == acc && i_q[IdxBits-1:0] < oj_q))
			                         ? ST_INS_DEC : ST_INS_PLACE;
			ST_INS_DEC:    state_d = ST_INS_RD_ORD;
			ST_INS_PLACE:  state_d = ST_INS_START;
			ST_CHK_START:  state_d = (n_q < cnt_t'(3) || i_q < cnt_t'(1)) ? ST_FAIL
			                                                            : ST_CHK_RD_ORD;
			ST_CHK_RD_ORD: state_d = ST_CHK_RD_PT;
			ST_CHK_RD_PT:  state_d = ST_CHK_M1;
			ST_CHK_M1:     state_d = ST_CHK_M2;
			ST_CHK_M2:     state_d = ST_CHK_DEC;
			ST_CHK_DEC:    state_d = (acc != 0) ? ST_OUT_RD : ST_CHK_START;
			ST_OUT_RD:     state_d = ST_OUT_WAIT;
			ST_OUT_WAIT:   state_d = ST_OUT_SHOW;
			ST_OUT_SHOW:   if (out_acc) state_d = end_of_run ? ST_LOAD : ST_OUT_RD;
			ST_FAIL:       if (out_acc) state_d = ST_LOAD;
			default:       state_d = ST_LOAD;
		endcase
	end

	// outputs and datapath controls
	always_comb begin
		in_stall = (state_q != ST_LOAD);
		out_valid = (state_q == ST_OUT_SHOW) || (state_q == ST_FAIL);
		no_polygon = (state_q == ST_FAIL);
		point_index = (state_q == ST_FAIL) ? 6'd0 : 6'(ord_rd);
		end_of_run = (state_q == ST_FAIL) ||
		             (tail_q ? (i_q == cnt_t'(got_q) + 1'b1) :
		              (i_q == cnt_t'(got_q) && n_q - 1'b1 == cnt_t'(got_q)));
		pt_addr = i_q[IdxBits-1:0];
		ord_addr = idx_t'(j_q - 1'b1);
		ord_we = 1'b0;
		ord_wa = j_q[IdxBits-1:0];
		ord_wd = oj_q;
		mac_ctl = '{en: 1'b0, op: MAC_LOAD_MUL};
		mac_a = dif(ax_q, rx_q);
		mac_b = dif(by_q, ry_q);
		case (state_q)
			ST_LOAD: ord_addr = '0;
			// reference goes first in the order
			ST_INS_START: begin
				ord_we = 1'b1;
				ord_wa = '0;
				ord_wd = ref_q;
			end
			ST_INS_RD_PT: pt_addr = ord_rd;
			// second operand arrives from the store in this cycle
			ST_INS_M1, ST_CHK_M1: begin
				mac_ctl = '{en: 1'b1, op: MAC_LOAD_MUL};
				mac_b = dif(py_rd, ry_q);
			end
			ST_INS_M2, ST_CHK_M2: begin
				mac_ctl = '{en: 1'b1, op: MAC_SUB_MUL};
				mac_a = dif(ay_q, ry_q);
				mac_b = dif(bx_q, rx_q);
			end
			ST_INS_D1: begin
				// dist2(i) = dx^2 then dy^2, dist2(j) below
				mac_ctl = '{en: 1'b1, op: dstep_q[0] ? MAC_ADD_MUL : MAC_LOAD_MUL};
				mac_a = dstep_q[1] ? dif(bx_q, rx_q) : dif(ax_q, rx_q);
				mac_b = mac_a;
				if (dstep_q[0]) begin
					mac_a = dstep_q[1] ? dif(by_q, ry_q) : dif(ay_q, ry_q);
					mac_b = mac_a;
				end
			end
			ST_INS_PLACE: begin
				ord_we = 1'b1;
				ord_wd = i_q[IdxBits-1:0];
			end
			ST_INS_DEC: begin
				ord_we = 1'b1;
				ord_wa = j_q[IdxBits-1:0];
				ord_wd = oj_q;
			end
			ST_CHK_START: ord_addr = idx_t'(n_q - 1'b1);
			ST_CHK_RD_ORD: begin
				ord_addr = i_q[IdxBits-1:0];
				pt_addr = ord_rd;
			end
			ST_CHK_RD_PT: pt_addr = ord_rd;
			ST_OUT_RD, ST_OUT_WAIT, ST_OUT_SHOW: ord_addr = i_q[IdxBits-1:0];
			default: ;
		endcase
		if (state_q == ST_INS_D1 && dphase_q == 1'b0) mac_ctl.en = 1'b0;
		if (state_q == ST_INS_D2) mac_ctl.en = 1'b0;
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			ref_q <= '0;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			m_q <= '0;
			tail_q <= 1'b0;
			dphase_q <= 1'b0;
			dstep_q <= '0;
			got_q <= '0;
			t_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: if (in_acc) begin
					if (final_point) begin
						n_q <= (cnt_q < cnt_t'(MaxPoints)) ? cnt_q + 1'b1 : cnt_q;
						cnt_q <= '0;
						ref_q <= '0;
						i_q <= '0;
						tail_q <= 1'b0;
					end else if (cnt_q < cnt_t'(MaxPoints)) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_REF_CMP: begin
					if (i_q == '0 || py_rd < cy_q || (py_rd == cy_q && px_rd < cx_q))
						ref_q <= i_q[IdxBits-1:0];
					if (i_q + 1'b1 >= n_q) begin
						i_q <= '0;
						m_q <= cnt_t'(1);
					end else i_q <= i_q + 1'b1;
				end
				ST_INS_START: begin
					if (i_q < n_q && i_q[IdxBits-1:0] == ref_q) i_q <= i_q + 1'b1;
					else if (i_q >= n_q) i_q <= n_q - cnt_t'(2);
					j_q <= m_q;
					dphase_q <= 1'b0;
					dstep_q <= '0;
				end
				ST_INS_D1: begin
					if (!dphase_q) begin
						if (acc == 0) dphase_q <= 1'b1;
					end else begin
						if (dstep_q == 2'd2) t_q <= acc;
						dstep_q <= dstep_q + 1'b1;
					end
				end
				ST_INS_DEC: begin
					j_q <= j_q - 1'b1;
					dphase_q <= 1'b0;
					dstep_q <= '0;
				end
				ST_INS_PLACE: begin
					i_q <= i_q + 1'b1;
					m_q <= m_q + 1'b1;
				end
				ST_CHK_DEC: begin
					if (acc != 0) begin
						got_q <= i_q[IdxBits-1:0];
						i_q <= '0;
					end else i_q <= i_q - 1'b1;
				end
				ST_OUT_SHOW: if (out_acc) begin
					if (!tail_q && i_q == cnt_t'(got_q)) begin
						tail_q <= 1'b1;
						i_q <= n_q - 1'b1;
					end else if (tail_q) i_q <= i_q - 1'b1;
					else i_q <= i_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers: coordinates of reference and compare operands
	always_ff @(posedge clk) begin
		case (state_q)
			ST_REF_CMP: if (i_q == '0 || py_rd < cy_q || (py_rd == cy_q && px_rd < cx_q)) begin
				cx_q <= px_rd;
				cy_q <= py_rd;
			end
			ST_INS_START: begin
				rx_q <= cx_q;
				ry_q <= cy_q;
			end
			ST_INS_RD_PT: begin
				oj_q <= ord_rd;
				ax_q <= px_rd;
				ay_q <= py_rd;
			end
			ST_INS_M1: begin
				bx_q <= px_rd;
				by_q <= py_rd;
			end
			ST_CHK_RD_ORD: oj_q <= ord_rd;
			ST_CHK_RD_PT: begin
				ax_q <= px_rd;
				ay_q <= py_rd;
			end
			ST_CHK_M1: begin
				bx_q <= px_rd;
				by_q <= py_rd;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/core/sppo_mac.sv @@
// sppo_mac: shared signed multiply-accumulate used for cross products and distances
// depends on sppo_pkg
`timescale 1ns / 1ps
`default_nettype none
module sppo_mac (
	input  wire                clk,
	input  sppo_pkg::mac_ctl_t ctl,
	input  sppo_pkg::diff_t    op_a,
	input  sppo_pkg::diff_t    op_b,
	output sppo_pkg::acc_t     acc
);
	import sppo_pkg::*;

	logic signed [ProdBits-1:0] prod;
	acc_t acc_q;

	assign prod = op_a * op_b;
	assign acc = acc_q;

	// accumulate one product per cycle while ctl.en is set
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			case (ctl.op)
				MAC_LOAD_MUL: acc_q <= AccBits'(prod);
				MAC_SUB_MUL:  acc_q <= acc_q - AccBits'(prod);
				MAC_ADD_MUL:  acc_q <= acc_q + AccBits'(prod);
				default:      acc_q <= acc_q;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ test/simple_polygon_polar_order_test.sv @@
// simple_polygon_polar_order_test: self-checking bench for the polar-angle polygon orderer
// depends on sppo_pkg and the simple_polygon_polar_order top level
`timescale 1ns / 1ps
module simple_polygon_polar_order_test;
	import sppo_pkg::*;

	typedef struct {
		logic [5:0] idx;
		logic       none;
		logic       last;
	} vertex_t;

	typedef struct {
		int x;
		int y;
		bit fin;
		bit typed;
	} row_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	coord_t coord_x;
	coord_t coord_y;
	logic   final_point;
	logic   out_valid;
	logic   out_stall;
	logic [5:0] point_index;
	logic   no_polygon;
	logic   end_of_run;

	// predictor state: stored points and fill count of the current set
	longint pt_x[MaxPoints];
	longint pt_y[MaxPoints];
	int     pt_count;
	vertex_t vertex_q[$];
	int     mismatches;
	int     rx_cycle;
	int     hold_until;

	simple_polygon_polar_order dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.coord_x(coord_x), .coord_y(coord_y), .final_point(final_point),
		.out_valid(out_valid), .out_stall(out_stall),
		.point_index(point_index), .no_polygon(no_polygon), .end_of_run(end_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("simple_polygon_polar_order_test: errors");
		$finish;
	end

	// append one expected vertex beat
	task automatic add_expected(vertex_t v);
		vertex_q = {vertex_q, v};
	endtask

	function automatic longint cross_about(int o, int a, int b);
		return (pt_x[a] - pt_x[o]) * (pt_y[b] - pt_y[o]) -
			(pt_y[a] - pt_y[o]) * (pt_x[b] - pt_x[o]);
	endfunction

	function automatic longint dist_sq(int o, int a);
		longint dx;
		longint dy;
		dx = pt_x[a] - pt_x[o];
		dy = pt_y[a] - pt_y[o];
		return dx * dx + dy * dy;
	endfunction

	// strict angular order about the reference, nearer first, then input order
	function automatic bit angle_before(int r, int i, int j);
		longint k;
		k = cross_about(r, i, j);
		if (k != 0) return k > 0;
		if (dist_sq(r, i) != dist_sq(r, j)) return dist_sq(r, i) < dist_sq(r, j);
		return i < j;
	endfunction

	// order the loaded set and queue the expected vertex beats
	task automatic order_polygon();
		int n;
		int r;
		int m;
		int j;
		int cut;
		int order[MaxPoints];
		vertex_t v;
		n = pt_count;
		pt_count = 0;
		r = 0;
		for (int i = 1; i < n; i++)
			if (pt_y[i] < pt_y[r] || (pt_y[i] == pt_y[r] && pt_x[i] < pt_x[r])) r = i;
		order[0] = r;
		m = 1;
		for (int i = 0; i < n; i++) begin
			if (i == r) continue;
			j = m;
			while (j > 1 && angle_before(r, i, order[j-1])) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
			m++;
		end
		cut = 0;
		if (n >= 3)
			for (int i = n - 2; i >= 1; i--)
				if (cross_about(order[0], order[n-1], order[i]) != 0) begin
					cut = i;
					break;
				end
		if (cut == 0) begin
			v.idx = 6'd0; v.none = 1'b1; v.last = 1'b1;
			add_expected(v);
			return;
		end
		v.none = 1'b0;
		v.last = 1'b0;
		for (int i = 0; i <= cut; i++) begin
			v.idx = 6'(order[i]);
			add_expected(v);
		end
		for (int i = n - 1; i > cut; i--) begin
			v.idx = 6'(order[i]);
			v.last = (i == cut + 1);
			add_expected(v);
		end
	endtask

	// offer one point beat and wait for it to be taken
	task automatic send_point(int x, int y, bit fin, bit typed);
		vertex_t v;
		@(negedge clk);
		in_valid <= 1'b1;
		coord_x <= coord_t'(x);
		coord_y <= coord_t'(y);
		final_point <= fin;
		do @(posedge clk); while (in_stall);
		if (pt_count < MaxPoints) begin
			pt_x[pt_count] = x;
			pt_y[pt_count] = y;
			pt_count++;
		end
		if (fin) begin
			if (typed) begin
				// degenerate set: single impossible beat
				pt_count = 0;
				v.idx = 6'd0; v.none = 1'b1; v.last = 1'b1;
				add_expected(v);
			end else begin
				order_polygon();
			end
		end
	endtask

	task automatic idle(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// receiver stall pattern plus a long hold-off window
	initial begin
		int mode;
		out_stall = 1'b0;
		rx_cycle = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle % 40 == 0) mode = $urandom_range(0, 3);
			if (rx_cycle < hold_until) out_stall <= 1'b1;
			else case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= $urandom_range(0, 1);
				default: out_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// compare each taken result beat with the oldest expected vertex
	always @(posedge clk) begin
		vertex_t v;
		if (arst_n && out_valid && !out_stall) begin
			if (vertex_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: idx %0d none %b last %b",
						point_index, no_polygon, end_of_run);
			end else begin
				v = vertex_q.pop_front();
				if (point_index !== v.idx || no_polygon !== v.none || end_of_run !== v.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp idx %0d none %b last %b, got %0d %b %b",
							v.idx, v.none, v.last, point_index, no_polygon, end_of_run);
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		int sent;
		int sets;
		int n;
		int kind;
		int burst;
		int bx;
		int by;
		int dx;
		int dy;
		int t;
		in_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;
		final_point = 1'b0;
		arst_n = 1'b0;
		mismatches = 0;
		pt_count = 0;
		hold_until = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed sets: too few, collinear, extremes, coincident, collinear tail
		rows = '{
			'{0, 0, 1, 1},
			'{-32768, -32768, 0, 0}, '{32767, 32767, 1, 1},
			'{0, 0, 0, 0}, '{5, 5, 0, 0}, '{-3, -3, 1, 1},
			'{-32768, -32768, 0, 0}, '{32767, -32768, 0, 0}, '{-32768, 32767, 1, 0},
			'{10, 10, 0, 0}, '{10, 10, 0, 0}, '{20, 10, 0, 0}, '{10, 20, 1, 0},
			'{0, 0, 0, 0}, '{2, 0, 0, 0}, '{2, 2, 0, 0}, '{1, 1, 0, 0},
			'{0, 1, 0, 0}, '{0, 2, 1, 0}
		};
		foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].fin, rows[i].typed);
		idle(1);
		wait (vertex_q.size() == 0);

		// random sets, mostly small; one oversized set exercises the capacity drop
		sent = 0;
		sets = 0;
		burst = 0;
		while (sent < 230) begin
			if (sets == 3) hold_until = rx_cycle + 600;
			if (sets == 7) begin
				idle(1);
				wait (vertex_q.size() == 0);
			end
			n = (sets == 10) ? 70 : ($urandom_range(0, 9) == 0 ? $urandom_range(1, 2)
				: $urandom_range(3, 9));
			kind = $urandom_range(0, 3);
			bx = $urandom_range(0, 2000) - 1000;
			by = $urandom_range(0, 2000) - 1000;
			dx = $urandom_range(0, 6) - 3;
			dy = $urandom_range(0, 6) - 3;
			for (int k = 0; k < n; k++) begin
				if (burst == 0 && sets != 3 && sets != 4) begin
					idle($urandom_range(0, 5));
					burst = $urandom_range(1, 12);
				end
				if (burst > 0) burst--;
				t = $urandom_range(0, 100) - 50;
				case (kind)
					0, 1: send_point($urandom_range(0, 65535) - 32768,
						$urandom_range(0, 65535) - 32768, k == n - 1, 0);
					2: send_point($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
						k == n - 1, 0);
					default: send_point(bx + t * dx, by + t * dy, k == n - 1, 0);
				endcase
				sent++;
			end
			sets++;
		end
		idle(1);
		wait (vertex_q.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("simple_polygon_polar_order_test: clean");
		else
			$display("simple_polygon_polar_order_test: errors");
		$finish;
	end
endmodule

@@ files.f @@
rtl/core/sppo_pkg.sv
rtl/core/sppo_mac.sv
rtl/core/simple_polygon_polar_order.sv
test/simple_polygon_polar_order_test.sv
